// File: rtl/prss_pkg.sv
// shared types and constants for the page range spec selector
// no dependencies; used by page_range_spec_selector and its testbench
package prss_pkg;

  localparam int RANGE_SLOTS_DEF = 16;
  localparam int MAX_PAGE_DEF    = 1000000000;

  // width of a stored bound, enough for +-MAX_PAGE at its largest
  localparam int VAL_W  = 31;
  localparam int PAGE_W = 32;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_MORE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERROR = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  localparam logic CMD_CHAR  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic                     cmd;
    logic [CHAR_W-1:0]        char_code;
    logic signed [PAGE_W-1:0] page;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              selected;
  } out_rsp_t;

endpackage

// File: rtl/prss_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module prss_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/page_range_spec_selector.sv
// page range spec selector: character parser, range table and membership query
// a spec character passes through ST_CHAR and ST_DONE to a registered result; a query walks
// the stored ranges in ST_QRUN and stops early on a hit, using one range comparator on the table ram
// throughput: one request at a time, the next taken the cycle after its result is registered;
// a new request is taken while a result waits on out_stall
// reset: synchronous active-low rst_n clears parser state and range count, not the table ram
module page_range_spec_selector #(
  parameter int RANGE_SLOTS = prss_pkg::RANGE_SLOTS_DEF,
  parameter int MAX_PAGE    = prss_pkg::MAX_PAGE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  prss_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output prss_pkg::out_rsp_t out_data
);

  import prss_pkg::*;

  localparam int IDX_W  = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(RANGE_SLOTS + 1);
  localparam int WIDE_W = VAL_W + 5;

  localparam logic signed [VAL_W-1:0] MAX_V = VAL_W'(MAX_PAGE);
  localparam logic signed [VAL_W-1:0] MIN_V = -MAX_V;
  localparam logic signed [WIDE_W-1:0] MAX_W = WIDE_W'(MAX_PAGE);
  localparam logic signed [WIDE_W-1:0] MIN_W = -MAX_W;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(RANGE_SLOTS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CHAR = 4'b0010,
    ST_QRUN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  in_req_t req_r;

  logic                     gath_r, gath_nxt;
  logic                     mark_r, mark_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [VAL_W-1:0]  acc_r, acc_nxt;
  logic signed [VAL_W-1:0]  pend_r, pend_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     cmp_pend_r, cmp_pend_nxt;
  logic [STAT_W-1:0]        res_status_r, res_status_nxt;
  logic                     res_sel_r, res_sel_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_rsp_t                 out_data_r, out_data_nxt;

  logic                     wr_en;
  logic signed [VAL_W-1:0]  wr_lo, wr_hi;
  logic                     rd_en;
  logic [2*VAL_W-1:0]       rd_data;
  logic signed [VAL_W-1:0]  rd_lo, rd_hi;
  logic                     in_range;
  logic                     last;

  logic [CHAR_W-1:0]        ch;
  logic                     is_sep, is_nul, is_digit, is_mark;
  logic signed [WIDE_W-1:0] acc_w, prod, dig, val;
  logic signed [VAL_W-1:0]  sat_val;

  prss_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (RANGE_SLOTS),
    .ADDR_W(IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count_r[IDX_W-1:0]),
    .wdata({wr_lo, wr_hi}),
    .re   (rd_en),
    .raddr(rd_idx_r[IDX_W-1:0]),
    .rdata(rd_data)
  );

  assign rd_lo = rd_data[2*VAL_W-1:VAL_W];
  assign rd_hi = rd_data[VAL_W-1:0];

  // shared range comparator
  assign in_range = (req_r.page >= PAGE_W'(rd_lo)) && (req_r.page <= PAGE_W'(rd_hi));
  assign last     = (rd_idx_r == count_r);

  // character classes
  assign ch       = req_r.char_code;
  assign is_nul   = (ch == CH_NUL);
  assign is_sep   = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_COMMA);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_mark  = (ch == CH_MINUS) || (ch == CH_COLON);

  // accumulator times ten plus or minus the digit, then saturate
  assign acc_w = WIDE_W'(acc_r);
  assign prod  = (acc_w <<< 3) + (acc_w <<< 1);
  assign dig   = WIDE_W'({1'b0, ch - CH_ZERO});
  assign val   = neg_r ? (prod - dig) : (prod + dig);
  always_comb begin
    if (val > MAX_W) begin
      sat_val = MAX_V;
    end else if (val < MIN_W) begin
      sat_val = MIN_V;
    end else begin
      sat_val = val[VAL_W-1:0];
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    gath_nxt       = gath_r;
    mark_nxt       = mark_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    pend_nxt       = pend_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_pend_nxt   = cmp_pend_r;
    res_status_nxt = res_status_r;
    res_sel_nxt    = res_sel_r;
    wr_en          = 1'b0;
    wr_lo          = pend_r;
    wr_hi          = MAX_V;
    rd_en          = 1'b0;

    if (!gath_r) begin
      wr_hi = MAX_V;
      wr_lo = mark_r ? pend_r : MIN_V;
    end else begin
      wr_hi = acc_r;
      wr_lo = mark_r ? pend_r : acc_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_QUERY) begin
            state_nxt    = ST_QRUN;
            rd_idx_nxt   = '0;
            cmp_pend_nxt = 1'b0;
          end else begin
            state_nxt = ST_CHAR;
          end
        end
      end
      ST_CHAR: begin
        state_nxt      = ST_DONE;
        res_sel_nxt    = 1'b0;
        res_status_nxt = STAT_MORE;
        if (!gath_r && !mark_r && (is_nul || is_sep)) begin
          res_status_nxt = is_nul ? STAT_DONE : STAT_MORE;
        end else if ((ch == CH_MINUS) && !gath_r) begin
          gath_nxt = 1'b1;
          neg_nxt  = 1'b1;
          acc_nxt  = '0;
        end else if (is_digit) begin
          if (!gath_r) begin
            gath_nxt = 1'b1;
            neg_nxt  = 1'b0;
            acc_nxt  = VAL_W'({1'b0, ch - CH_ZERO});
          end else begin
            acc_nxt = sat_val;
          end
        end else if (is_mark) begin
          if (mark_r) begin
            res_status_nxt = STAT_ERROR;
            gath_nxt = 1'b0;
            mark_nxt = 1'b0;
            neg_nxt  = 1'b0;
            acc_nxt  = '0;
            pend_nxt = '0;
          end else begin
            pend_nxt = gath_r ? acc_r : MIN_V;
            mark_nxt = 1'b1;
            gath_nxt = 1'b0;
          end
        end else if (is_nul || is_sep) begin
          if (count_r >= SLOTS_C) begin
            res_status_nxt = STAT_FULL;
            gath_nxt = 1'b0;
            mark_nxt = 1'b0;
            neg_nxt  = 1'b0;
            acc_nxt  = '0;
            pend_nxt = '0;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            mark_nxt  = 1'b0;
            gath_nxt  = 1'b0;
            if (is_nul) begin
              res_status_nxt = STAT_DONE;
              neg_nxt  = 1'b0;
              acc_nxt  = '0;
              pend_nxt = '0;
            end
          end
        end else begin
          // stray character
          res_status_nxt = STAT_ERROR;
          gath_nxt = 1'b0;
          mark_nxt = 1'b0;
          neg_nxt  = 1'b0;
          acc_nxt  = '0;
          pend_nxt = '0;
        end
      end
      ST_QRUN: begin
        res_status_nxt = STAT_MORE;
        if (cmp_pend_r && in_range) begin
          res_sel_nxt = 1'b1;
          state_nxt   = ST_DONE;
        end else if (last) begin
          res_sel_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          // read next entry while the previous one is compared
          rd_en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          cmp_pend_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_DONE) && (!out_valid_r || !out_stall)) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.status   = res_status_r;
      out_data_nxt.selected = res_sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gath_r      <= 1'b0;
      mark_r      <= 1'b0;
      neg_r       <= 1'b0;
      acc_r       <= '0;
      pend_r      <= '0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gath_r      <= gath_nxt;
      mark_r      <= mark_nxt;
      neg_r       <= neg_nxt;
      acc_r       <= acc_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_valid) begin
      req_r <= in_data;
    end
    res_status_r <= res_status_nxt;
    res_sel_r    <= res_sel_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: tb/sv/page_range_spec_selector_tb.sv
// self-checking testbench for page_range_spec_selector: spec characters and page queries
// are predicted by an in-bench parser and range table, results checked in order
// depends on prss_pkg and the page_range_spec_selector rtl
module page_range_spec_selector_tb;
  import prss_pkg::*;

  localparam int MAXP           = MAX_PAGE_DEF;
  localparam int SLOTS          = RANGE_SLOTS_DEF;
  localparam int RAND_ITEMS     = 1700;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  out_rsp_t out_data;

  always #5 clk = ~clk;

  page_range_spec_selector u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // parser and range table mirror
  logic                    parse_num;
  logic                    parse_mark;
  logic                    parse_neg;
  logic signed [VAL_W-1:0] parse_acc;
  logic signed [VAL_W-1:0] parse_low;
  logic signed [VAL_W-1:0] range_lo [SLOTS];
  logic signed [VAL_W-1:0] range_hi [SLOTS];
  int unsigned             range_cnt;

  out_rsp_t        due_rsp_q[$];
  logic [CHAR_W-1:0] spec_buf[$];

  bit idle_on;
  bit long_hold_req;
  int err_cnt;
  int n_sent, n_chars, n_queries, n_hits, n_done, n_syntax, n_full;

  function automatic bit is_sep(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_COMMA;
  endfunction

  function automatic void clear_parse();
    parse_num  = 1'b0;
    parse_mark = 1'b0;
    parse_neg  = 1'b0;
    parse_acc  = '0;
    parse_low  = '0;
  endfunction

  function automatic logic [STAT_W-1:0] parse_char(input logic [CHAR_W-1:0] c);
    longint                  d;
    longint                  v;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    if (!parse_num && !parse_mark) begin
      if (c == CH_NUL) return STAT_DONE;
      if (is_sep(c)) return STAT_MORE;
    end
    if (c == CH_MINUS && !parse_num) begin
      parse_num = 1'b1;
      parse_neg = 1'b1;
      parse_acc = '0;
      return STAT_MORE;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = longint'(c) - longint'(CH_ZERO);
      if (!parse_num) begin
        parse_num = 1'b1;
        parse_neg = 1'b0;
        parse_acc = VAL_W'(d);
        return STAT_MORE;
      end
      v = longint'(parse_acc) * 10;
      v = parse_neg ? v - d : v + d;
      if (v > MAXP) v = MAXP;
      if (v < -longint'(MAXP)) v = -longint'(MAXP);
      parse_acc = VAL_W'(v);
      return STAT_MORE;
    end
    if (c == CH_MINUS || c == CH_COLON) begin
      if (parse_mark) begin
        clear_parse();
        return STAT_ERROR;
      end
      parse_low  = parse_num ? parse_acc : VAL_W'(-MAXP);
      parse_mark = 1'b1;
      parse_num  = 1'b0;
      return STAT_MORE;
    end
    if (c == CH_NUL || is_sep(c)) begin
      lo = parse_low;
      if (!parse_num) begin
        hi = VAL_W'(MAXP);
        if (!parse_mark) lo = VAL_W'(-MAXP);
      end else begin
        hi = parse_acc;
        if (!parse_mark) lo = hi;
      end
      if (range_cnt >= SLOTS) begin
        clear_parse();
        return STAT_FULL;
      end
      range_lo[range_cnt] = lo;
      range_hi[range_cnt] = hi;
      range_cnt++;
      if (c == CH_NUL) begin
        clear_parse();
        return STAT_DONE;
      end
      parse_mark = 1'b0;
      parse_num  = 1'b0;
      return STAT_MORE;
    end
    clear_parse();
    return STAT_ERROR;
  endfunction

  function automatic logic page_in_table(input logic signed [PAGE_W-1:0] p);
    for (int unsigned k = 0; k < range_cnt; k++) begin
      if (longint'(p) >= longint'(range_lo[k]) && longint'(p) <= longint'(range_hi[k]))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_rsp_t parse_or_lookup(input in_req_t req);
    out_rsp_t rsp;
    if (req.cmd == CMD_QUERY) begin
      rsp.status   = STAT_MORE;
      rsp.selected = page_in_table(req.page);
    end else begin
      rsp.status   = parse_char(req.char_code);
      rsp.selected = 1'b0;
    end
    return rsp;
  endfunction

  // pages biased toward stored bounds and the saturation limits
  function automatic logic signed [PAGE_W-1:0] pick_page();
    int          r;
    int unsigned k;
    longint      base;
    r = $urandom_range(0, 99);
    if (r < 40 && range_cnt > 0) begin
      k    = $urandom_range(0, range_cnt - 1);
      base = $urandom_range(0, 1) ? longint'(range_lo[k]) : longint'(range_hi[k]);
      return PAGE_W'(base + longint'(int'($urandom_range(0, 2))) - 1);
    end
    if (r < 55) begin
      base = $urandom_range(0, 1) ? longint'(MAXP) : -longint'(MAXP);
      return PAGE_W'(base + longint'(int'($urandom_range(0, 2))) - 1);
    end
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fffffff;
        1:       return 32'sh80000000;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    if (r < 80) return PAGE_W'(int'($urandom_range(0, 2000)) - 1000);
    return PAGE_W'($urandom);
  endfunction

  task automatic send_request(input in_req_t req);
    int       gap;
    out_rsp_t rsp;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    rsp = parse_or_lookup(req);
    due_rsp_q.push_back(rsp);
    n_sent++;
    if (req.cmd == CMD_QUERY) begin
      n_queries++;
      if (rsp.selected) n_hits++;
    end else begin
      n_chars++;
      if (rsp.status == STAT_DONE) n_done++;
      if (rsp.status == STAT_ERROR) n_syntax++;
      if (rsp.status == STAT_FULL) n_full++;
    end
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c);
    in_req_t req;
    req.cmd       = CMD_CHAR;
    req.char_code = c;
    req.page      = $urandom;
    send_request(req);
  endtask

  task automatic send_query(input logic signed [PAGE_W-1:0] p);
    in_req_t req;
    req.cmd       = CMD_QUERY;
    req.char_code = CHAR_W'($urandom_range(0, 255));
    req.page      = p;
    send_request(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_number();
    int r;
    int ndig;
    bit neg;
    neg = ($urandom_range(0, 3) == 0);
    if (neg) spec_buf.push_back(CH_MINUS);
    r    = $urandom_range(0, 99);
    ndig = (r < 5) ? 0 : (r < 60) ? $urandom_range(1, 3) :
           (r < 85) ? $urandom_range(4, 9) : $urandom_range(10, 12);
    repeat (ndig) spec_buf.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
  endtask

  task automatic add_entry();
    int                r;
    logic [CHAR_W-1:0] mark;
    mark = $urandom_range(0, 1) ? CH_MINUS : CH_COLON;
    r    = $urandom_range(0, 99);
    if (r < 40) begin
      add_number();
    end else if (r < 85) begin
      add_number();
      spec_buf.push_back(mark);
      add_number();
    end else if (r < 92) begin
      add_number();
      spec_buf.push_back(mark);
    end else if (r < 98) begin
      spec_buf.push_back(CH_COLON);
      add_number();
    end else begin
      spec_buf.push_back(mark);
    end
  endtask

  task automatic add_separators();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0:       spec_buf.push_back(CH_SPACE);
        1:       spec_buf.push_back(CH_TAB);
        default: spec_buf.push_back(CH_COMMA);
      endcase
    end
  endtask

  // mostly well-formed specs with random content, some broken, some plain noise
  task automatic build_spec();
    int                r;
    int                n_entries;
    logic [CHAR_W-1:0] c;
    spec_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(1, 6)) spec_buf.push_back(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) == 0) add_separators();
    n_entries = $urandom_range(1, 4);
    for (int i = 0; i < n_entries; i++) begin
      add_entry();
      if (i < n_entries - 1 || $urandom_range(0, 7) == 0) add_separators();
    end
    if (r < 13) begin
      do c = CHAR_W'($urandom_range(0, 255));
      while (c == CH_NUL || is_sep(c) || c == CH_MINUS || c == CH_COLON ||
             (c >= CH_ZERO && c <= CH_NINE));
      spec_buf.insert($urandom_range(0, spec_buf.size()), c);
    end else if (r < 18) begin
      // a range mark twice in a row always trips the parser
      spec_buf.push_back(CH_COLON);
      spec_buf.push_back(CH_COLON);
    end
    if (r < 98) spec_buf.push_back(CH_NUL);
  endtask

  task automatic test_empty_table();
    idle_on = 1'b1;
    send_query(32'sh80000000);
    send_query(32'sh7fffffff);
    send_char(CH_NUL);
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_char(CH_COMMA);
    send_char(8'hFF);
  endtask

  task automatic test_syntax_cases();
    // lone minus stores [0,0]
    send_text("-,");
    send_query(32'sd0);
    send_char(CH_COLON);
    send_char(CH_COLON);
  endtask

  task automatic test_saturation();
    send_text("9999999999,");
    send_query(MAXP);
    send_query(MAXP + 1);
  endtask

  // receiver holds off while requests keep coming, so the block fills and stalls
  task automatic test_backpressure();
    idle_on       = 1'b0;
    long_hold_req = 1'b1;
    send_text("10:20,30");
    send_char(CH_NUL);
    send_query(32'sd15);
    send_query(32'sd31);
  endtask

  task automatic test_random_specs();
    int start;
    start = n_sent;
    while (n_sent - start < RAND_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      build_spec();
      foreach (spec_buf[i]) begin
        if ($urandom_range(0, 3) == 0) send_query(pick_page());
        send_char(spec_buf[i]);
      end
    end
  endtask

  task automatic test_table_full();
    idle_on = 1'b1;
    send_text("3-4");
    send_char(CH_NUL);
    send_char(CH_TAB);
    send_text("5,");
    send_query(32'sd3);
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    idle_on       = 1'b1;
    long_hold_req = 1'b0;
    err_cnt       = 0;
    clear_parse();
    range_cnt = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_syntax_cases();
    test_saturation();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_specs();
    wait_drained();
    test_table_full();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d spec characters and %0d page queries (%0d selected)",
             n_chars, n_queries, n_hits);
    $display("specs completed %0d, syntax errors %0d, table full %0d, ranges stored %0d",
             n_done, n_syntax, n_full, range_cnt);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : rsp_sink
    int       stall_left;
    out_rsp_t want;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (due_rsp_q.size() == 0) begin
          $display("%0t: result with no request due, status %0d selected %0b",
                   $time, out_data.status, out_data.selected);
          err_cnt++;
        end else begin
          want = due_rsp_q.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, out_data.status);
            err_cnt++;
          end
          if (out_data.selected !== want.selected) begin
            $display("%0t: selected mismatch, expected %0b actual %0b",
                     $time, want.selected, out_data.selected);
            err_cnt++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule
